/* sv/assert_macros.svh */
// Assertion helpers, clocked on i_clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/tmcw_pkg.sv */
`timescale 1ns / 1ps

package tmcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int TAB_WIDTH = 7;
    localparam int TAB_CNT_W = $clog2(TAB_WIDTH);
    localparam int QDEPTH    = 2;
    localparam int PTR_W     = $clog2(QDEPTH);

    localparam logic [7:0] CH_EOS   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [7:0]       char_code;
        logic [COL_W-1:0] cell_col;
        logic [ROW_W-1:0] cell_row;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic             scrolled;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_READ,
        OP_PRINT,
        OP_TAB,
        OP_LF,
        OP_CR,
        OP_NEWLINE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             rd_ok;
        logic [7:0]       char_code;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_TAB,
        S_COPY,
        S_DRAIN,
        S_FILL
    } t_state;

endpackage

/* sv/tmcw_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmcw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tmcw_pkg::t_in_item i_item,
    output logic               o_cmd_valid,
    output tmcw_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);
    import tmcw_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;
    t_cmd             cls;
    logic             push_acc;
    logic             pop_acc;

    // classify the incoming transaction
    always_comb begin
        cls.char_code = i_item.char_code;
        cls.col       = i_item.cell_col;
        cls.row       = i_item.cell_row;
        cls.rd_ok     = ({1'b0, i_item.cell_col} < (COL_W + 1)'(COLUMNS)) &&
                        ({1'b0, i_item.cell_row} < (ROW_W + 1)'(ROWS));
        if (i_item.kind == KIND_READ) begin
            cls.op = OP_READ;
        end else begin
            unique case (i_item.char_code)
                CH_TAB:  cls.op = OP_TAB;
                CH_LF:   cls.op = OP_LF;
                CH_CR:   cls.op = OP_CR;
                CH_EOS:  cls.op = OP_NEWLINE;
                default: cls.op = OP_PRINT;
            endcase
        end
    end

    assign full        = (r_cnt == (PTR_W + 1)'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push_acc    = push && !full;
    assign pop_acc     = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push_acc) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_acc) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_acc) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W + 1)'(push_acc) - (PTR_W + 1)'(pop_acc);
        end
    end

    `ASSERT_CLK(a_q_count_range, r_cnt <= (PTR_W + 1)'(QDEPTH), "command queue count overrun")

endmodule

/* sv/tmcw_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmcw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  tmcw_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_empty,
    input  logic                i_res_pop,
    output tmcw_pkg::t_out_item o_item
);
    import tmcw_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic                 r_scroll;
    logic [ADDR_W-1:0]    r_idx;
    logic [ADDR_W-1:0]    r_pos;
    logic [ADDR_W-1:0]    r_cp_dst;
    logic                 r_cp_v;
    logic [TAB_CNT_W-1:0] r_k;
    logic                 r_rd_ok;
    logic [7:0]           r_attr;

    // screen store, character and attribute bytes kept apart
    logic [7:0]           r_mem_char [CELLS];
    logic [7:0]           r_mem_attr [CELLS];
    logic [7:0]           r_rd_char;
    logic [7:0]           r_rd_attr;
    logic                 mem_we_char;
    logic                 mem_we_attr;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [7:0]           mem_wchar;
    logic [7:0]           mem_wattr;

    t_out_item            r_oq [QDEPTH];
    logic [PTR_W-1:0]     r_owp;
    logic [PTR_W-1:0]     r_orp;
    logic [PTR_W:0]       r_ocnt;
    logic                 res_push;
    logic                 res_pop;
    t_out_item            res_item;

    logic [COL_W:0]       c_col;
    logic [ROW_W:0]       c_row;
    logic                 c_scroll;
    logic [ADDR_W-1:0]    cur_pos;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W:0]      tab_addr;
    logic                 cmd_go;
    logic                 tab_last;

    assign cmd_go   = (r_state == S_IDLE) && i_cmd_valid && (r_ocnt != (PTR_W + 1)'(QDEPTH));
    assign cur_pos  = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign rd_addr  = ADDR_W'(i_cmd.row) * ADDR_W'(COLUMNS) + ADDR_W'(i_cmd.col);
    assign tab_addr = {1'b0, r_pos} + (ADDR_W + 1)'(r_k);
    assign tab_last = (r_k == TAB_CNT_W'(TAB_WIDTH - 1));

    // cursor after a write transaction
    always_comb begin
        c_col = {1'b0, r_col};
        c_row = {1'b0, r_row};
        case (i_cmd.op)
            OP_TAB:     c_col = c_col + (COL_W + 1)'(TAB_WIDTH);
            OP_PRINT:   c_col = c_col + 1'b1;
            OP_LF:      c_row = c_row + 1'b1;
            OP_CR:      c_col = '0;
            OP_NEWLINE: begin
                c_col = '0;
                c_row = c_row + 1'b1;
            end
            default: ;
        endcase
        if (c_col >= (COL_W + 1)'(COLUMNS)) begin
            c_col = c_col - (COL_W + 1)'(COLUMNS);
            c_row = c_row + 1'b1;
        end
        c_scroll = 1'b0;
        if (c_row >= (ROW_W + 1)'(ROWS)) begin
            c_row    = (ROW_W + 1)'(ROWS - 1);
            c_scroll = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_go) begin
                    if (i_cmd.op == OP_READ) begin
                        n_state = S_RDWAIT;
                    end else if (i_cmd.op == OP_TAB) begin
                        n_state = S_TAB;
                    end else if (c_scroll) begin
                        n_state = S_COPY;
                    end
                end
            end
            S_RDWAIT: n_state = S_IDLE;
            S_TAB: begin
                if (tab_last) begin
                    n_state = r_scroll ? S_COPY : S_IDLE;
                end
            end
            S_COPY: begin
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_FILL;
            S_FILL: begin
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we_char = 1'b0;
        mem_we_attr = 1'b0;
        mem_waddr   = r_idx;
        mem_raddr   = r_idx;
        mem_wchar   = CH_SPACE;
        mem_wattr   = r_attr;
        o_cmd_pop   = 1'b0;
        res_push    = 1'b0;
        res_item    = '0;
        res_item.cursor_col = r_col;
        res_item.cursor_row = r_row;
        unique case (r_state)
            S_CLEAR: begin
                mem_we_char = 1'b1;
                mem_we_attr = 1'b1;
                mem_wchar   = '0;
                mem_wattr   = '0;
            end
            S_IDLE: begin
                o_cmd_pop = cmd_go;
                mem_raddr = i_cmd.rd_ok ? rd_addr : '0;
                if (cmd_go && i_cmd.op == OP_PRINT) begin
                    mem_we_char = 1'b1;
                    mem_waddr   = cur_pos;
                    mem_wchar   = i_cmd.char_code;
                end
                if (cmd_go && i_cmd.op != OP_READ && i_cmd.op != OP_TAB && !c_scroll) begin
                    res_push            = 1'b1;
                    res_item.cursor_col = c_col[COL_W-1:0];
                    res_item.cursor_row = c_row[ROW_W-1:0];
                end
            end
            S_RDWAIT: begin
                res_push = 1'b1;
                if (r_rd_ok) begin
                    res_item.cell_char = r_rd_char;
                    res_item.cell_attr = r_rd_attr;
                end
            end
            S_TAB: begin
                mem_we_char = (tab_addr < (ADDR_W + 1)'(CELLS));
                mem_waddr   = tab_addr[ADDR_W-1:0];
                res_push    = tab_last && !r_scroll;
            end
            S_COPY: begin
                mem_we_char = r_cp_v;
                mem_we_attr = r_cp_v;
                mem_waddr   = r_cp_dst;
                mem_wchar   = r_rd_char;
                mem_wattr   = r_rd_attr;
            end
            S_DRAIN: begin
                mem_we_char = 1'b1;
                mem_we_attr = 1'b1;
                mem_waddr   = r_cp_dst;
                mem_wchar   = r_rd_char;
                mem_wattr   = r_rd_attr;
            end
            S_FILL: begin
                mem_we_char = 1'b1;
                mem_we_attr = 1'b1;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    res_push          = 1'b1;
                    res_item.scrolled = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we_char) begin
            r_mem_char[mem_waddr] <= mem_wchar;
        end
        if (mem_we_attr) begin
            r_mem_attr[mem_waddr] <= mem_wattr;
        end
        r_rd_char <= r_mem_char[mem_raddr];
        r_rd_attr <= r_mem_attr[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cmd_go) begin
            r_pos   <= cur_pos;
            r_rd_ok <= i_cmd.rd_ok;
        end
        if (r_state == S_COPY) begin
            r_cp_dst <= r_idx - ADDR_W'(COLUMNS);
        end
        if (r_state == S_DRAIN) begin
            r_attr <= r_rd_attr;
        end
        if (res_push) begin
            r_oq[r_owp] <= res_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_scroll <= 1'b0;
            r_cp_v   <= 1'b0;
            r_k      <= '0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_idx <= r_idx + 1'b1;
                S_IDLE: begin
                    r_idx  <= ADDR_W'(COLUMNS);
                    r_cp_v <= 1'b0;
                    r_k    <= '0;
                    if (cmd_go && i_cmd.op != OP_READ) begin
                        r_col    <= c_col[COL_W-1:0];
                        r_row    <= c_row[ROW_W-1:0];
                        r_scroll <= c_scroll;
                    end
                end
                S_TAB:   r_k <= r_k + 1'b1;
                S_COPY: begin
                    r_idx  <= r_idx + 1'b1;
                    r_cp_v <= 1'b1;
                end
                S_DRAIN: r_idx <= ADDR_W'(CELLS - COLUMNS);
                S_FILL:  r_idx <= r_idx + 1'b1;
                default: ;
            endcase
            if (res_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (res_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + (PTR_W + 1)'(res_push) - (PTR_W + 1)'(res_pop);
        end
    end

    assign res_pop     = i_res_pop && (r_ocnt != '0);
    assign o_res_empty = (r_ocnt == '0);
    assign o_item      = r_oq[r_orp];

    `ASSERT_CLK(a_cursor_range, ({1'b0, r_col} < (COL_W + 1)'(COLUMNS)) && ({1'b0, r_row} < (ROW_W + 1)'(ROWS)), "cursor out of range")
    `ASSERT_IMPL(a_res_room, res_push, (r_ocnt != (PTR_W + 1)'(QDEPTH)) || res_pop, "result queue overflow")
    `ASSERT_IMPL(a_fill_bottom, r_state == S_FILL, r_scroll && (r_row == ROW_W'(ROWS - 1)), "fill without scroll")

endmodule

/* sv/text_mode_console_writer.sv */
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         push / full          i_item  (t_in_item)
// result    out        empty / pop          o_item  (t_out_item)
//
// Print, LF, CR and end of string finish at dispatch unless they scroll; a read waits for the registered store read;
// a tab writes spaces into 7 cells after dispatch. A scroll copies rows through the single store port, then fills.
// After reset the store is cleared, one cell a cycle, over all ROWS*COLUMNS cells.
// A two-entry command queue feeds the back end; a two-entry result queue absorbs pop stalls.

module text_mode_console_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tmcw_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output tmcw_pkg::t_out_item o_item
);
    import tmcw_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    tmcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    tmcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_empty (empty),
        .i_res_pop   (pop),
        .o_item      (o_item)
    );

endmodule
